@@ design/bgtr_pkg.sv @@
`default_nettype none

package bgtr_pkg;

   localparam logic [1:0] ACT_LOAD_GLYPH  = 2'd0;
   localparam logic [1:0] ACT_LOAD_BITMAP = 2'd1;
   localparam logic [1:0] ACT_DRAW        = 2'd2;

   localparam logic [1:0] CSR_FB_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_FB_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_FIRST_CHAR = 2'd2;

   localparam int REQ_TDATA_W = 136;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int ENTRY_W     = 56;
   localparam int SPAN_W      = 32;

   localparam logic [10:0] FB_WIDTH_RST   = 11'd320;
   localparam logic [10:0] FB_HEIGHT_RST  = 11'd240;
   localparam logic [7:0]  FIRST_CHAR_RST = 8'd32;

   typedef struct packed {
      logic [10:0] fb_width;
      logic [10:0] fb_height;
      logic [7:0]  first_char;
   } cfg_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic [15:0]        color;
      logic signed [11:0] pen_y;
      logic signed [11:0] pen_x;
      logic               new_text;
      logic [7:0]         char_code;
      logic [7:0]         bitmap_byte;
      logic [11:0]        bitmap_addr;
      logic [55:0]        glyph_entry;
      logic [6:0]         glyph_index;
   } req_data_type;

   typedef struct packed {
      logic [15:0]        pixel_color;
      logic [31:0]        pixel_mask;
      logic signed [11:0] span_x;
      logic signed [11:0] row_y;
   } rsp_data_type;

   typedef struct packed {
      logic [7:0]         char_code;
      logic               new_text;
      logic signed [11:0] pen_x;
      logic signed [11:0] pen_y;
      logic [15:0]        color;
   } draw_req_type;

   typedef struct packed {
      logic signed [7:0] yoff;
      logic signed [7:0] xoff;
      logic [7:0]        advance;
      logic [7:0]        height;
      logic [7:0]        width;
      logic [15:0]       offset;
   } glyph_type;

endpackage

`default_nettype wire

@@ design/bgtr_ram.sv @@
`default_nettype none

module bgtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/bgtr_csr.sv @@
`default_nettype none

module bgtr_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               wr_en,
   input  wire logic [bgtr_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  wire logic [bgtr_pkg::CSR_DATA_W-1:0]    wr_data,
   output bgtr_pkg::cfg_type                       cfg
);

   import bgtr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_FB_WIDTH:   cfg_in.fb_width   = wr_data[10:0];
            CSR_FB_HEIGHT:  cfg_in.fb_height  = wr_data[10:0];
            CSR_FIRST_CHAR: cfg_in.first_char = wr_data[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_width   <= FB_WIDTH_RST;
         cfg_ff.fb_height  <= FB_HEIGHT_RST;
         cfg_ff.first_char <= FIRST_CHAR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ design/bgtr_raster.sv @@
`default_nettype none

module bgtr_raster #(
   parameter int GLYPH_COUNT  = 128,
   parameter int BITMAP_BYTES = 4096,
   parameter int MAX_GLYPH_W  = 32,
   parameter int MAX_GLYPH_H  = 32,
   parameter int GI_W         = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1,
   parameter int BA_W         = $clog2(BITMAP_BYTES)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  bgtr_pkg::cfg_type                  cfg,
   input  wire logic                          draw_start,
   input  bgtr_pkg::draw_req_type             draw_req,
   output logic                               idle,
   output logic [GI_W-1:0]                    glyph_rd_addr,
   input  wire logic [bgtr_pkg::ENTRY_W-1:0]  glyph_rd_data,
   output logic [BA_W-1:0]                    bit_rd_addr,
   input  wire logic [7:0]                    bit_rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output bgtr_pkg::rsp_data_type             rsp_data,
   output logic                               rsp_last
);

   import bgtr_pkg::*;

   localparam int ROW_LIM   = (MAX_GLYPH_H < 32) ? MAX_GLYPH_H : 32;
   localparam int COL_LIM   = (MAX_GLYPH_W < 32) ? MAX_GLYPH_W : 32;
   localparam int RED_STEPS = 17 - $clog2(BITMAP_BYTES);
   localparam int RC_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
   localparam int WIN_BYTES = 5;
   localparam int WIN_W     = 8 * WIN_BYTES;
   localparam logic [BA_W:0] BYTES_C = (BA_W + 1)'(BITMAP_BYTES);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_FETCH  = 7'b0000010,
      S_DECODE = 7'b0000100,
      S_REDUCE = 7'b0001000,
      S_READ   = 7'b0010000,
      S_DRAIN  = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic signed [11:0] pen_x_ff, pen_x_in;
   logic signed [11:0] pen_y_ff, pen_y_in;
   logic [15:0]        color_ff, color_in;
   logic [GI_W-1:0]    rel_ff, rel_in;
   logic               rel_ok_ff, rel_ok_in;
   logic [15:0]        red_ff, red_in;
   logic [RC_W-1:0]    red_cnt_ff, red_cnt_in;
   logic [7:0]         w_ff, w_in;
   logic [5:0]         rows_ff, rows_in;
   logic [5:0]         cols_ff, cols_in;
   logic signed [13:0] x0_ff, x0_in;
   logic signed [13:0] y_ff, y_in;
   logic [4:0]         yy_ff, yy_in;
   logic [2:0]         ph_ff, ph_in;
   logic               empty_ff, empty_in;
   logic [BA_W-1:0]    row_addr_ff, row_addr_in;
   logic [BA_W-1:0]    rd_addr_ff, rd_addr_in;
   logic [2:0]         bcnt_ff, bcnt_in;
   logic               fetch_v_ff;
   logic [WIN_W-1:0]   win_ff;
   logic [SPAN_W-1:0]  col_mask_ff, col_mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff;
   logic               rsp_last_ff;

   logic [8:0]         rel9;
   glyph_type          entry;
   logic [31:0]        red_shift;
   logic               red_sub;
   logic [15:0]        red_next;
   logic [8:0]         ph_step;
   logic [BA_W-1:0]    next_row_addr;
   logic [WIN_W-1:0]   win_aligned;
   logic [SPAN_W-1:0]  row_bits;
   logic               row_ok;
   logic               last;
   logic               rsp_free;
   logic               rsp_load;
   rsp_data_type       rsp_data_in;

   function automatic logic [BA_W-1:0] add_wrap(input logic [BA_W-1:0] a, input logic [5:0] inc);
      logic [BA_W:0] s;
      s = {1'b0, a} + (BA_W + 1)'(inc);
      if (s >= BYTES_C) begin
         s = s - BYTES_C;
      end
      return s[BA_W-1:0];
   endfunction

   assign rel9     = {1'b0, draw_req.char_code} - {1'b0, cfg.first_char};
   assign entry    = rel_ok_ff ? glyph_type'(glyph_rd_data) : glyph_type'('0);

   assign red_shift = 32'(BITMAP_BYTES) << red_cnt_ff;
   assign red_sub   = {16'd0, red_ff} >= red_shift;
   assign red_next  = red_sub ? (red_ff - red_shift[15:0]) : red_ff;

   assign ph_step       = {6'd0, ph_ff} + {1'b0, w_ff};
   assign next_row_addr = add_wrap(row_addr_ff, ph_step[8:3]);

   assign win_aligned = win_ff << ph_ff;
   always_comb begin
      for (int i = 0; i < SPAN_W; i++) begin
         row_bits[i] = win_aligned[WIN_W-1-i];
      end
   end

   always_comb begin
      logic signed [13:0] xi;
      for (int i = 0; i < SPAN_W; i++) begin
         xi = x0_ff + 14'(i);
         col_mask_in[i] = !xi[13] && (xi[12:0] < {2'b00, cfg.fb_width}) &&
                          (6'(i) < cols_ff);
      end
   end

   assign row_ok   = !y_ff[13] && (y_ff[12:0] < {2'b00, cfg.fb_height});
   assign last     = empty_ff || (({1'b0, yy_ff} + 6'd1) == rows_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      color_in    = color_ff;
      rel_in      = rel_ff;
      rel_ok_in   = rel_ok_ff;
      red_in      = red_ff;
      red_cnt_in  = red_cnt_ff;
      w_in        = w_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      x0_in       = x0_ff;
      y_in        = y_ff;
      yy_in       = yy_ff;
      ph_in       = ph_ff;
      empty_in    = empty_ff;
      row_addr_in = row_addr_ff;
      rd_addr_in  = rd_addr_ff;
      bcnt_in     = bcnt_ff;
      rsp_load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (draw_start) begin
               color_in  = draw_req.color;
               rel_in    = rel9[GI_W-1:0];
               rel_ok_in = !rel9[8] && ({1'b0, rel9[7:0]} < 9'(GLYPH_COUNT));
               if (draw_req.new_text) begin
                  pen_x_in = draw_req.pen_x;
                  pen_y_in = draw_req.pen_y;
               end
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_DECODE;
         end
         S_DECODE: begin
            red_in     = entry.offset;
            red_cnt_in = RC_W'(RED_STEPS - 1);
            w_in       = entry.width;
            rows_in    = (entry.height > 8'(ROW_LIM)) ? 6'(ROW_LIM) : entry.height[5:0];
            cols_in    = (entry.width > 8'(COL_LIM)) ? 6'(COL_LIM) : entry.width[5:0];
            x0_in      = 14'(pen_x_ff) + 14'(entry.xoff);
            y_in       = 14'(pen_y_ff) + 14'(entry.yoff);
            yy_in      = '0;
            ph_in      = '0;
            empty_in   = (entry.height == 8'd0);
            pen_x_in   = pen_x_ff + 12'(entry.advance);
            state_in   = S_REDUCE;
         end
         S_REDUCE: begin
            red_in     = red_next;
            red_cnt_in = red_cnt_ff - 1'b1;
            if (red_cnt_ff == '0) begin
               row_addr_in = red_next[BA_W-1:0];
               rd_addr_in  = red_next[BA_W-1:0];
               bcnt_in     = '0;
               state_in    = empty_ff ? S_EMIT : S_READ;
            end
         end
         S_READ: begin
            rd_addr_in = add_wrap(rd_addr_ff, 6'd1);
            bcnt_in    = bcnt_ff + 3'd1;
            if (bcnt_ff == 3'(WIN_BYTES - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (last) begin
                  state_in = S_IDLE;
               end else begin
                  yy_in       = yy_ff + 5'd1;
                  y_in        = y_ff + 14'sd1;
                  ph_in       = ph_step[2:0];
                  row_addr_in = next_row_addr;
                  rd_addr_in  = next_row_addr;
                  bcnt_in     = '0;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in.row_y       = y_ff[11:0];
      rsp_data_in.span_x      = x0_ff[11:0];
      rsp_data_in.pixel_mask  = (empty_ff || !row_ok) ? '0 : (row_bits & col_mask_ff);
      rsp_data_in.pixel_color = color_ff;
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         fetch_v_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         fetch_v_ff   <= (state_ff == S_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      rel_ff      <= rel_in;
      rel_ok_ff   <= rel_ok_in;
      red_ff      <= red_in;
      red_cnt_ff  <= red_cnt_in;
      w_ff        <= w_in;
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      x0_ff       <= x0_in;
      y_ff        <= y_in;
      yy_ff       <= yy_in;
      ph_ff       <= ph_in;
      empty_ff    <= empty_in;
      row_addr_ff <= row_addr_in;
      rd_addr_ff  <= rd_addr_in;
      bcnt_ff     <= bcnt_in;
      col_mask_ff <= col_mask_in;
      if (fetch_v_ff) begin
         win_ff <= {win_ff[WIN_W-9:0], bit_rd_data};
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last;
      end
   end

   assign idle          = (state_ff == S_IDLE);
   assign glyph_rd_addr = rel_ff;
   assign bit_rd_addr   = rd_addr_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_last      = rsp_last_ff;

   a_reduce_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REDUCE && red_cnt_ff == '0) |=> ({1'b0, row_addr_ff} < BYTES_C))
      else $error("bitmap row address left the store range");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ({1'b0, rd_addr_ff} < BYTES_C))
      else $error("bitmap read address out of range");

   a_empty_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && empty_ff) |=> (rsp_data_ff.pixel_mask == '0 && rsp_last_ff))
      else $error("empty glyph transaction carries pixels or is not last");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after the final span");

   a_fetch_window: assert property (@(posedge clock) disable iff (reset)
      fetch_v_ff |-> (state_ff == S_READ || state_ff == S_DRAIN))
      else $error("bitmap data returned outside a row fetch");

endmodule

`default_nettype wire

@@ design/bitmap_glyph_text_rasterizer_core.sv @@
// Channel  Direction  Handshake                  Payload
// req      in         req_tvalid / req_tready    req_tdata, req_tuser (action)
// rsp      out        rsp_tvalid / rsp_tready    rsp_tdata, rsp_tlast (last span)
// csr      in         csr_valid / csr_ready      csr_index, csr_data
//
// A load transaction writes the glyph table or the bitmap store.
// A draw transaction first runs its setup (glyph fetch, decode and the offset reduction
// loop), then emits one span per glyph row, each after five bitmap RAM reads through
// its single read port; an empty glyph gives one span after setup.
// A stalled result holds in the output register; the next transaction is taken once
// the sequencer is back in idle, even if that last span is still waiting.
// Reset clears the pen and the control state and returns the configuration registers to their defaults, only.
`default_nettype none

module bitmap_glyph_text_rasterizer_core #(
   parameter int GLYPH_COUNT  = 128,
   parameter int BITMAP_BYTES = 4096,
   parameter int MAX_GLYPH_W  = 32,
   parameter int MAX_GLYPH_H  = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // glyph_index, glyph_entry, bitmap_addr, bitmap_byte, char_code, new_text,
   // pen_x, pen_y, color, zero fill
   input  wire logic [bgtr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  wire logic [bgtr_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // row_y, span_x, pixel_mask, pixel_color
   output logic [bgtr_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bgtr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bgtr_pkg::CSR_DATA_W-1:0]    csr_data
);

   import bgtr_pkg::*;

   localparam int GI_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int BA_W = $clog2(BITMAP_BYTES);

   req_data_type      req_d;
   draw_req_type      draw_req;
   cfg_type           cfg;
   rsp_data_type      rsp_d;
   logic              req_accept;
   logic              idle;
   logic              glyph_we;
   logic              bit_we;
   logic [7:0]        glyph_wr_full;
   logic [15:0]       bit_wr_full;
   logic [GI_W-1:0]   glyph_rd_addr;
   logic [ENTRY_W-1:0] glyph_rd_data;
   logic [BA_W-1:0]   bit_rd_addr;
   logic [7:0]        bit_rd_data;

   assign req_d      = req_tdata;
   assign req_tready = idle;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign glyph_we = req_accept && (req_tuser == ACT_LOAD_GLYPH) &&
                     (9'(req_d.glyph_index) < 9'(GLYPH_COUNT));
   assign bit_we   = req_accept && (req_tuser == ACT_LOAD_BITMAP) &&
                     (17'(req_d.bitmap_addr) < 17'(BITMAP_BYTES));
   assign glyph_wr_full = 8'(req_d.glyph_index);
   assign bit_wr_full   = 16'(req_d.bitmap_addr);

   assign draw_req.char_code = req_d.char_code;
   assign draw_req.new_text  = req_d.new_text;
   assign draw_req.pen_x     = req_d.pen_x;
   assign draw_req.pen_y     = req_d.pen_y;
   assign draw_req.color     = req_d.color;

   bgtr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   bgtr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (GLYPH_COUNT),
      .AW    (GI_W)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (glyph_we),
      .wr_addr (glyph_wr_full[GI_W-1:0]),
      .wr_data (req_d.glyph_entry),
      .rd_addr (glyph_rd_addr),
      .rd_data (glyph_rd_data)
   );

   bgtr_ram #(
      .WIDTH (8),
      .DEPTH (BITMAP_BYTES),
      .AW    (BA_W)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bit_we),
      .wr_addr (bit_wr_full[BA_W-1:0]),
      .wr_data (req_d.bitmap_byte),
      .rd_addr (bit_rd_addr),
      .rd_data (bit_rd_data)
   );

   bgtr_raster #(
      .GLYPH_COUNT  (GLYPH_COUNT),
      .BITMAP_BYTES (BITMAP_BYTES),
      .MAX_GLYPH_W  (MAX_GLYPH_W),
      .MAX_GLYPH_H  (MAX_GLYPH_H),
      .GI_W         (GI_W),
      .BA_W         (BA_W)
   ) u_raster (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .draw_start    (req_accept && (req_tuser == ACT_DRAW)),
      .draw_req      (draw_req),
      .idle          (idle),
      .glyph_rd_addr (glyph_rd_addr),
      .glyph_rd_data (glyph_rd_data),
      .bit_rd_addr   (bit_rd_addr),
      .bit_rd_data   (bit_rd_data),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_data      (rsp_d),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = rsp_d;

endmodule

`default_nettype wire
